### rtl/owt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// owt_pkg
// Shared types and constants for the 1-Wire master slot timer.
// ----------------------------------------------------------------------------
package owt_pkg;

    localparam int TIME_W = 10;
    localparam int REG_COUNT = 8;
    localparam int REG_IDX_W = $clog2(REG_COUNT);

    typedef logic [TIME_W-1:0] time_t;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_RESET = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FAIL = 2'd1,
        ST_BUSY = 2'd2
    } status_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_RESET_LOW    = 3'd0,
        REG_RESET_SAMPLE = 3'd1,
        REG_RESET_TAIL   = 3'd2,
        REG_WRITE0_LOW   = 3'd3,
        REG_WRITE0_HIGH  = 3'd4,
        REG_WRITE1_LOW   = 3'd5,
        REG_WRITE1_HIGH  = 3'd6,
        REG_READ_LOW     = 3'd7
    } reg_idx_t;

    localparam time_t RESET_LOW_INIT    = 10'd480;
    localparam time_t RESET_SAMPLE_INIT = 10'd70;
    localparam time_t RESET_TAIL_INIT   = 10'd410;
    localparam time_t WRITE0_LOW_INIT   = 10'd60;
    localparam time_t WRITE0_HIGH_INIT  = 10'd10;
    localparam time_t WRITE1_LOW_INIT   = 10'd6;
    localparam time_t WRITE1_HIGH_INIT  = 10'd64;
    localparam time_t READ_LOW_INIT     = 10'd6;

    localparam time_t READ_SAMPLE_TIME = 10'd9;
    localparam time_t READ_TAIL_TIME   = 10'd55;

    typedef struct packed {
        time_t reset_low;
        time_t reset_sample;
        time_t reset_tail;
        time_t write0_low;
        time_t write0_high;
        time_t write1_low;
        time_t write1_high;
        time_t read_low;
    } timing_t;

endpackage

`default_nettype wire

### rtl/owt_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// owt_if
// Valid/ready channels for commands/ticks and per-item results.
// ----------------------------------------------------------------------------
interface owt_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic       write_value;
    logic       line_level;

    modport source (output valid, output op, output write_value, output line_level,
                    input ready);
    modport sink   (input valid, input op, input write_value, input line_level,
                    output ready);
endinterface

interface owt_res_if;
    logic       valid;
    logic       ready;
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic       read_value;

    modport source (output valid, output drive_low, output busy_res, output done_res,
                    output status, output read_value, input ready);
    modport sink   (input valid, input drive_low, input busy_res, input done_res,
                    input status, input read_value, output ready);
endinterface

`default_nettype wire

### rtl/owt_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// owt_cfg_regs
// Slot timing register file, write-only, loaded with standard-speed values.
// ----------------------------------------------------------------------------
module owt_cfg_regs (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           cfg_we,
    input  wire  [owt_pkg::REG_IDX_W-1:0] cfg_index,
    input  wire  [owt_pkg::TIME_W-1:0]    cfg_data,
    output owt_pkg::timing_t              timing
);
    import owt_pkg::*;

    timing_t timing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_reg.reset_low    <= RESET_LOW_INIT;
            timing_reg.reset_sample <= RESET_SAMPLE_INIT;
            timing_reg.reset_tail   <= RESET_TAIL_INIT;
            timing_reg.write0_low   <= WRITE0_LOW_INIT;
            timing_reg.write0_high  <= WRITE0_HIGH_INIT;
            timing_reg.write1_low   <= WRITE1_LOW_INIT;
            timing_reg.write1_high  <= WRITE1_HIGH_INIT;
            timing_reg.read_low     <= READ_LOW_INIT;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_RESET_LOW:    timing_reg.reset_low    <= cfg_data;
                REG_RESET_SAMPLE: timing_reg.reset_sample <= cfg_data;
                REG_RESET_TAIL:   timing_reg.reset_tail   <= cfg_data;
                REG_WRITE0_LOW:   timing_reg.write0_low   <= cfg_data;
                REG_WRITE0_HIGH:  timing_reg.write0_high  <= cfg_data;
                REG_WRITE1_LOW:   timing_reg.write1_low   <= cfg_data;
                REG_WRITE1_HIGH:  timing_reg.write1_high  <= cfg_data;
                REG_READ_LOW:     timing_reg.read_low     <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign timing = timing_reg;

endmodule

`default_nettype wire

### rtl/onewire_master_slot_timer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// onewire_master_slot_timer
// 1-Wire standard-speed bus master: reset, write and read slot timing.
// ----------------------------------------------------------------------------
// One item (a command or a 1 us tick) is taken per clock. Its result is ready
// in the output register in the cycle after the transfer; the slot state update
// is a single compare, decrement and reload of the 10-bit countdown. The input
// stays ready while the output register is empty or being drained that cycle,
// so a stalled result holds off only the next transfer.
// ----------------------------------------------------------------------------
module onewire_master_slot_timer (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           cfg_we,
    input  wire  [owt_pkg::REG_IDX_W-1:0] cfg_index,
    input  wire  [owt_pkg::TIME_W-1:0]    cfg_data,
    owt_cmd_if.sink                       cmd,
    owt_res_if.source                     res
);
    import owt_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_RST_LOW  = 4'd1,
        PH_RST_WAIT = 4'd2,
        PH_RST_TAIL = 4'd3,
        PH_W0_LOW   = 4'd4,
        PH_W0_HIGH  = 4'd5,
        PH_W1_LOW   = 4'd6,
        PH_W1_HIGH  = 4'd7,
        PH_RD_LOW   = 4'd8,
        PH_RD_WAIT  = 4'd9,
        PH_RD_TAIL  = 4'd10
    } phase_t;

    timing_t timing;

    phase_t  phase_reg,   phase_next;
    time_t   count_reg,   count_next;
    logic    pulled_reg,  pulled_next;
    status_t status_reg,  status_next;
    logic    sampled_reg, sampled_next;
    logic    done_next;
    logic    reject_next;

    logic    out_valid_reg;
    logic    drive_reg;
    logic    busy_reg;
    logic    done_reg;
    status_t res_status_reg;
    logic    read_reg;

    logic    xfer;
    op_t     op;

    owt_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .timing    (timing)
    );

    assign cmd.ready = !out_valid_reg || res.ready;
    assign xfer      = cmd.valid && cmd.ready;
    assign op        = op_t'(cmd.op);

    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        pulled_next  = pulled_reg;
        status_next  = status_reg;
        sampled_next = sampled_reg;
        done_next    = 1'b0;
        reject_next  = 1'b0;

        if (op != OP_TICK)
        begin
            if (phase_reg != PH_IDLE)
            begin
                reject_next = 1'b1;
            end
            else
            begin
                unique case (op)
                    OP_RESET:
                    begin
                        if (!cmd.line_level)
                        begin
                            status_next = ST_FAIL;
                            done_next   = 1'b1;
                        end
                        else
                        begin
                            status_next = ST_OK;
                            pulled_next = 1'b1;
                            phase_next  = PH_RST_LOW;
                            count_next  = timing.reset_low;
                        end
                    end
                    OP_WRITE:
                    begin
                        status_next = ST_OK;
                        pulled_next = 1'b1;
                        if (cmd.write_value)
                        begin
                            phase_next = PH_W1_LOW;
                            count_next = timing.write1_low;
                        end
                        else
                        begin
                            phase_next = PH_W0_LOW;
                            count_next = timing.write0_low;
                        end
                    end
                    default:
                    begin
                        status_next = ST_OK;
                        pulled_next = 1'b1;
                        phase_next  = PH_RD_LOW;
                        count_next  = timing.read_low;
                    end
                endcase
            end
        end
        else if (phase_reg != PH_IDLE)
        begin
            if (count_reg > time_t'(1))
            begin
                count_next = count_reg - time_t'(1);
            end
            else
            begin
                count_next = '0;
                unique case (phase_reg)
                    PH_RST_LOW:
                    begin
                        pulled_next = 1'b0;
                        phase_next  = PH_RST_WAIT;
                        count_next  = timing.reset_sample;
                    end
                    PH_RST_WAIT:
                    begin
                        status_next = cmd.line_level ? ST_FAIL : ST_OK;
                        phase_next  = PH_RST_TAIL;
                        count_next  = timing.reset_tail;
                    end
                    PH_W0_LOW:
                    begin
                        pulled_next = 1'b0;
                        phase_next  = PH_W0_HIGH;
                        count_next  = timing.write0_high;
                    end
                    PH_W1_LOW:
                    begin
                        pulled_next = 1'b0;
                        phase_next  = PH_W1_HIGH;
                        count_next  = timing.write1_high;
                    end
                    PH_RD_LOW:
                    begin
                        pulled_next = 1'b0;
                        phase_next  = PH_RD_WAIT;
                        count_next  = READ_SAMPLE_TIME;
                    end
                    PH_RD_WAIT:
                    begin
                        sampled_next = cmd.line_level;
                        phase_next   = PH_RD_TAIL;
                        count_next   = READ_TAIL_TIME;
                    end
                    default:
                    begin
                        // tail and recovery phases close the slot
                        pulled_next = 1'b0;
                        phase_next  = PH_IDLE;
                        done_next   = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            count_reg      <= '0;
            pulled_reg     <= 1'b0;
            status_reg     <= ST_OK;
            sampled_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            drive_reg      <= 1'b0;
            busy_reg       <= 1'b0;
            done_reg       <= 1'b0;
            res_status_reg <= ST_OK;
            read_reg       <= 1'b0;
        end
        else
        begin
            if (xfer)
            begin
                phase_reg      <= phase_next;
                count_reg      <= count_next;
                pulled_reg     <= pulled_next;
                status_reg     <= status_next;
                sampled_reg    <= sampled_next;
                out_valid_reg  <= 1'b1;
                drive_reg      <= pulled_next;
                busy_reg       <= (phase_next != PH_IDLE);
                done_reg       <= done_next;
                res_status_reg <= reject_next ? ST_BUSY : status_next;
                read_reg       <= sampled_next;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.drive_low  = drive_reg;
    assign res.busy_res   = busy_reg;
    assign res.done_res   = done_reg;
    assign res.status     = res_status_reg;
    assign res.read_value = read_reg;

`ifndef SYNTHESIS
    a_pull_only_in_slot: assert property (@(posedge clk) disable iff (!rst_n)
        pulled_reg |-> (phase_reg != PH_IDLE))
        else $error("line pulled while no slot is active");

    a_result_follows_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        xfer |=> res.valid)
        else $error("transfer produced no result");

    a_done_ends_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.done_res) |-> (!res.busy_res && !res.drive_low))
        else $error("done reported while slot still active");

    a_reject_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (xfer && (op != OP_TICK) && (phase_reg != PH_IDLE))
            |=> (res.status == ST_BUSY) && res.busy_res)
        else $error("busy command not rejected");
`endif

endmodule

`default_nettype wire
